// ----- rtl/gbcv_pkg.sv -----
// Shared constants for the bridge and cut vertex counter.
// Field widths and default sizes; no dependencies.
package gbcv_pkg;
    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_EDGES    = 2048;
    localparam int VERTEX_W         = 11;
    localparam int CUT_W            = 11;
    localparam int BRIDGE_W         = 10;
endpackage

// ----- rtl/graph_bridge_cut_vertex_counter.sv -----
// Top level of the bridge and cut vertex counter: edge loader, clearing pass
// and iterative depth-first walk over one vertex memory. Uses gbcv_pkg.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    has_edge, end_a, end_b, last_edge
//   out      output     out_valid / out_stall  cut_vertex_count, bridge_count, load_error
//   cfg      input      cfg_valid / cfg_ready  cfg_data (vertex_count)
//
// An edge beat runs S_IDLE, S_LA, S_LB0 and S_LB: two read-modify-writes of the vertex
// memory, one per end. The walk runs S_ROOT, S_ROOT2 per root; S_TOP, S_TOP2, S_NB, S_W
// (and S_W2 for a new child) per stored slot; S_TOP, S_TOP2, S_PR, S_P per return to a
// parent. A clearing pass over vertex entries 0..MAX_VERTICES follows reset and each
// result; no input beat is taken meanwhile. A finished walk holds while a result stalls.
module graph_bridge_cut_vertex_counter
    import gbcv_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                has_edge,
    input  logic [VERTEX_W-1:0] end_a,
    input  logic [VERTEX_W-1:0] end_b,
    input  logic                last_edge,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [CUT_W-1:0]    cut_vertex_count,
    output logic [BRIDGE_W-1:0] bridge_count,
    output logic                load_error,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [VERTEX_W-1:0] cfg_data
);
    localparam int VSIZE = MAX_VERTICES + 1;
    localparam int CAP   = 2 * MAX_EDGES;
    localparam int VW    = $clog2(VSIZE);
    localparam int RW    = VW + 1;
    localparam int CW    = (RW > VERTEX_W) ? RW : VERTEX_W;
    localparam int SW    = $clog2(CAP + 1);
    localparam int AW    = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int STW   = $clog2(MAX_VERTICES);

    localparam logic [SW-1:0] EMPTY  = SW'(CAP);
    localparam logic [CW-1:0] MAXV_C = CW'(MAX_VERTICES);
    localparam logic [SW:0]   CAP_C  = (SW+1)'(CAP);

    typedef struct packed {
        logic [SW-1:0] head;
        logic [VW-1:0] visit;
        logic [VW-1:0] low;
        logic [VW-1:0] parent;
        logic          cut;
        logic [1:0]    child;
        logic [SW-1:0] resume;
    } vword_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LA, S_LB0, S_LB, S_ROOT, S_ROOT2,
        S_TOP, S_TOP2, S_NB, S_W, S_W2, S_PR, S_P
    } state_t;

    vword_t        vmem [VSIZE];
    logic [VW-1:0] sl_nb_mem [CAP];
    logic [SW-1:0] sl_nx_mem [CAP];
    logic [VW-1:0] st_mem [MAX_VERTICES];

    vword_t        vm_rd, vm_wdata;
    logic [VW-1:0] vm_raddr, vm_waddr;
    logic          vm_we;
    logic [VW-1:0] sl_nb_rd, sl_nb_w;
    logic [SW-1:0] sl_nx_rd, sl_nx_w;
    logic [AW-1:0] sl_raddr, sl_waddr;
    logic          sl_we;
    logic [VW-1:0] st_rd, st_wdata;
    logic [STW-1:0] st_raddr, st_waddr;
    logic          st_we;

    state_t        state_reg, state_next;
    logic [VW-1:0] clr_reg, clr_next;
    logic [VERTEX_W-1:0] vc_reg, vc_next;
    logic [VW-1:0] a_reg, a_next, b_reg, b_next;
    logic          last_reg, last_next;
    logic [SW-1:0] slots_reg, slots_next;
    logic          err_reg, err_next;
    logic [RW-1:0] root_reg, root_next;
    logic [VW-1:0] stamp_reg, stamp_next;
    logic [VW-1:0] sp_reg, sp_next;
    logic [VW-1:0] v_reg, v_next, w_reg, w_next;
    vword_t        vw_reg, vw_next;
    logic [CW-1:0] cuts_reg, cuts_next, brg_reg, brg_next;
    logic          out_valid_reg, out_valid_next;
    logic [CUT_W-1:0]    out_cut_reg, out_cut_next;
    logic [BRIDGE_W-1:0] out_brg_reg, out_brg_next;
    logic          out_err_reg, out_err_next;

    logic [CW-1:0] n_eff, a_ext, b_ext;
    logic [SW:0]   slots_plus2;
    logic          edge_ok, cut_now;
    logic [VW-1:0] stamp_inc;
    vword_t        wtmp;

    always_ff @(posedge clk)
    begin
        if (vm_we)
        begin
            vmem[vm_waddr] <= vm_wdata;
        end
        vm_rd <= vmem[vm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sl_we)
        begin
            sl_nb_mem[sl_waddr] <= sl_nb_w;
            sl_nx_mem[sl_waddr] <= sl_nx_w;
        end
        sl_nb_rd <= sl_nb_mem[sl_raddr];
        sl_nx_rd <= sl_nx_mem[sl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_waddr] <= st_wdata;
        end
        st_rd <= st_mem[st_raddr];
    end

    assign n_eff       = (CW'(vc_reg) > MAXV_C) ? MAXV_C : CW'(vc_reg);
    assign a_ext       = CW'(end_a);
    assign b_ext       = CW'(end_b);
    assign slots_plus2 = (SW+1)'(slots_reg) + (SW+1)'(2);
    assign edge_ok     = (a_ext != '0) && (b_ext != '0) && (a_ext <= n_eff)
                         && (b_ext <= n_eff) && (slots_plus2 <= CAP_C);
    assign stamp_inc   = stamp_reg + VW'(1);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        vc_next        = vc_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        last_next      = last_reg;
        slots_next     = slots_reg;
        err_next       = err_reg;
        root_next      = root_reg;
        stamp_next     = stamp_reg;
        sp_next        = sp_reg;
        v_next         = v_reg;
        w_next         = w_reg;
        vw_next        = vw_reg;
        cuts_next      = cuts_reg;
        brg_next       = brg_reg;
        out_valid_next = out_valid_reg;
        out_cut_next   = out_cut_reg;
        out_brg_next   = out_brg_reg;
        out_err_next   = out_err_reg;
        vm_raddr = v_reg;
        vm_we    = 1'b0;
        vm_waddr = v_reg;
        vm_wdata = vw_reg;
        sl_raddr = vw_reg.resume[AW-1:0];
        sl_we    = 1'b0;
        sl_waddr = slots_reg[AW-1:0];
        sl_nb_w  = b_reg;
        sl_nx_w  = vm_rd.head;
        st_raddr = STW'(sp_reg - VW'(2));
        st_we    = 1'b0;
        st_waddr = sp_reg[STW-1:0];
        st_wdata = v_reg;
        wtmp     = vm_rd;
        cut_now  = 1'b0;

        if (cfg_valid)
        begin
            vc_next = cfg_data;
        end
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                vm_we    = 1'b1;
                vm_waddr = clr_reg;
                vm_wdata = '{head: EMPTY, visit: '0, low: '0, parent: clr_reg,
                             cut: 1'b0, child: 2'd0, resume: EMPTY};
                clr_next = clr_reg + VW'(1);
                if (clr_reg == VW'(MAX_VERTICES))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                vm_raddr = end_a[VW-1:0];
                if (in_valid)
                begin
                    a_next    = a_ext[VW-1:0];
                    b_next    = b_ext[VW-1:0];
                    last_next = last_edge;
                    stamp_next = '0;
                    brg_next   = '0;
                    cuts_next  = '0;
                    root_next  = RW'(1);
                    if (has_edge && !edge_ok)
                    begin
                        err_next = 1'b1;
                    end
                    if (has_edge && edge_ok)
                    begin
                        state_next = S_LA;
                    end
                    else if (last_edge)
                    begin
                        state_next = S_ROOT;
                    end
                end
            end
            S_LA:
            begin
                sl_we    = 1'b1;
                sl_nb_w  = b_reg;
                vm_we    = 1'b1;
                vm_waddr = a_reg;
                wtmp.head = slots_reg;
                vm_wdata = wtmp;
                slots_next = slots_reg + SW'(1);
                state_next = S_LB0;
            end
            S_LB0:
            begin
                vm_raddr   = b_reg;
                state_next = S_LB;
            end
            S_LB:
            begin
                sl_we    = 1'b1;
                sl_nb_w  = a_reg;
                vm_we    = 1'b1;
                vm_waddr = b_reg;
                wtmp.head = slots_reg;
                vm_wdata = wtmp;
                slots_next = slots_reg + SW'(1);
                state_next = last_reg ? S_ROOT : S_IDLE;
            end
            S_ROOT:
            begin
                vm_raddr = root_reg[VW-1:0];
                if (CW'(root_reg) > n_eff)
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_cut_next   = cuts_reg[CUT_W-1:0];
                        out_brg_next   = brg_reg[BRIDGE_W-1:0];
                        out_err_next   = err_reg;
                        slots_next     = '0;
                        err_next       = 1'b0;
                        clr_next       = '0;
                        state_next     = S_CLEAR;
                    end
                end
                else
                begin
                    state_next = S_ROOT2;
                end
            end
            S_ROOT2:
            begin
                if (vm_rd.visit == '0)
                begin
                    wtmp.visit  = stamp_inc;
                    wtmp.low    = stamp_inc;
                    wtmp.resume = vm_rd.head;
                    vm_we       = 1'b1;
                    vm_waddr    = root_reg[VW-1:0];
                    vm_wdata    = wtmp;
                    stamp_next  = stamp_inc;
                    st_we       = 1'b1;
                    st_waddr    = '0;
                    st_wdata    = root_reg[VW-1:0];
                    sp_next     = VW'(1);
                    v_next      = root_reg[VW-1:0];
                    state_next  = S_TOP;
                end
                else
                begin
                    root_next  = root_reg + RW'(1);
                    state_next = S_ROOT;
                end
            end
            S_TOP:
            begin
                state_next = S_TOP2;
            end
            S_TOP2:
            begin
                vw_next  = vm_rd;
                sl_raddr = vm_rd.resume[AW-1:0];
                if (vm_rd.resume != EMPTY)
                begin
                    state_next = S_NB;
                end
                else
                begin
                    sp_next = sp_reg - VW'(1);
                    if (sp_reg == VW'(1))
                    begin
                        root_next  = root_reg + RW'(1);
                        state_next = S_ROOT;
                    end
                    else
                    begin
                        state_next = S_PR;
                    end
                end
            end
            S_NB:
            begin
                w_next         = sl_nb_rd;
                vw_next.resume = sl_nx_rd;
                vm_raddr       = sl_nb_rd;
                state_next     = S_W;
            end
            S_W:
            begin
                vm_we    = 1'b1;
                vm_waddr = v_reg;
                vm_wdata = vw_reg;
                if (vm_rd.visit == '0)
                begin
                    if (vw_reg.child != 2'd2)
                    begin
                        vm_wdata.child = vw_reg.child + 2'd1;
                    end
                    wtmp.parent = v_reg;
                    wtmp.visit  = stamp_inc;
                    wtmp.low    = stamp_inc;
                    wtmp.resume = vm_rd.head;
                    vw_next     = wtmp;
                    stamp_next  = stamp_inc;
                    state_next  = S_W2;
                end
                else
                begin
                    if ((vw_reg.parent != w_reg) && (vm_rd.visit < vw_reg.low))
                    begin
                        vm_wdata.low = vm_rd.visit;
                    end
                    state_next = S_TOP;
                end
            end
            S_W2:
            begin
                vm_we      = 1'b1;
                vm_waddr   = w_reg;
                vm_wdata   = vw_reg;
                st_we      = 1'b1;
                st_waddr   = sp_reg[STW-1:0];
                st_wdata   = w_reg;
                sp_next    = sp_reg + VW'(1);
                v_next     = w_reg;
                state_next = S_TOP;
            end
            S_PR:
            begin
                w_next     = st_rd;
                vm_raddr   = st_rd;
                state_next = S_P;
            end
            S_P:
            begin
                if (vw_reg.low < vm_rd.low)
                begin
                    wtmp.low = vw_reg.low;
                end
                if (vm_rd.visit < vw_reg.low)
                begin
                    brg_next = brg_reg + CW'(1);
                end
                if (vm_rd.parent == w_reg)
                begin
                    cut_now = (vm_rd.child == 2'd2);
                end
                else
                begin
                    cut_now = (vw_reg.low >= vm_rd.visit);
                end
                if (cut_now)
                begin
                    wtmp.cut = 1'b1;
                    if (!vm_rd.cut)
                    begin
                        cuts_next = cuts_reg + CW'(1);
                    end
                end
                vm_we      = 1'b1;
                vm_waddr   = w_reg;
                vm_wdata   = wtmp;
                v_next     = w_reg;
                state_next = S_TOP;
            end
            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            vc_reg        <= VERTEX_W'(1);
            last_reg      <= 1'b0;
            slots_reg     <= '0;
            err_reg       <= 1'b0;
            root_reg      <= '0;
            stamp_reg     <= '0;
            sp_reg        <= '0;
            cuts_reg      <= '0;
            brg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            vc_reg        <= vc_next;
            last_reg      <= last_next;
            slots_reg     <= slots_next;
            err_reg       <= err_next;
            root_reg      <= root_next;
            stamp_reg     <= stamp_next;
            sp_reg        <= sp_next;
            cuts_reg      <= cuts_next;
            brg_reg       <= brg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        v_reg       <= v_next;
        w_reg       <= w_next;
        vw_reg      <= vw_next;
        out_cut_reg <= out_cut_next;
        out_brg_reg <= out_brg_next;
        out_err_reg <= out_err_next;
    end

    assign in_stall         = (state_reg != S_IDLE);
    assign cfg_ready        = 1'b1;
    assign out_valid        = out_valid_reg;
    assign cut_vertex_count = out_cut_reg;
    assign bridge_count     = out_brg_reg;
    assign load_error       = out_err_reg;
endmodule
